/* hw/rtl/ansp_pkg.sv */
`timescale 1ns / 1ps

package ansp_pkg;

	// Special bytes of a NameString
	localparam logic [7:0] ROOT_CHAR    = 8'h5C;
	localparam logic [7:0] PARENT_CHAR  = 8'h5E;
	localparam logic [7:0] DUAL_PREFIX  = 8'h2E;
	localparam logic [7:0] MULTI_PREFIX = 8'h2F;
	localparam logic [7:0] NULL_NAME    = 8'h00;
	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_Z       = 8'h5A;
	localparam logic [7:0] CHAR_US      = 8'h5F;
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] PARENT_MAX   = 8'hFF;

	// Position of the last char of a segment
	localparam logic [1:0] TAIL_CHARS = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_SEG   = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_LEAD_CHAR  = 2'd1;
	localparam logic [1:0] ERR_NAME_CHAR  = 2'd2;
	localparam logic [1:0] ERR_PATH_START = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_PREFIX = 5'b00010,
		PH_PATH   = 5'b00100,
		PH_COUNT  = 5'b01000,
		PH_SEG    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_new;
	} in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] segment_name;
		logic [7:0]  segment_index;
		logic        is_last;
		logic        root_present;
		logic [7:0]  parent_depth;
		logic [7:0]  segment_count;
		logic [1:0]  error_code;
	} out_t;

	typedef struct packed {
		phase_t      phase;
		logic        root_seen;
		logic [7:0]  parent_count;
		logic [7:0]  segments_total;
		logic [7:0]  segments_done;
		logic [1:0]  char_position;
		logic [23:0] segment_acc;
	} state_t;

	localparam state_t STATE_CLEAR = '{
		phase:          PH_IDLE,
		root_seen:      1'b0,
		parent_count:   8'd0,
		segments_total: 8'd0,
		segments_done:  8'd0,
		char_position:  2'd0,
		segment_acc:    24'd0
	};

	typedef struct packed {
		state_t st;
		logic   emit;
		out_t   res;
	} step_t;

endpackage

/* hw/rtl/ansp_step.sv */
`timescale 1ns / 1ps

module ansp_step (
	input  ansp_pkg::state_t state,
	input  ansp_pkg::in_t    data,
	output ansp_pkg::state_t next_state,
	output logic             emit,
	output ansp_pkg::out_t   res
);

	function automatic logic is_lead(input logic [7:0] b);
		return (b inside {[ansp_pkg::CHAR_A:ansp_pkg::CHAR_Z]}) || (b == ansp_pkg::CHAR_US);
	endfunction

	function automatic logic is_name(input logic [7:0] b);
		return is_lead(b) || (b inside {[ansp_pkg::CHAR_0:ansp_pkg::CHAR_9]});
	endfunction

	function automatic ansp_pkg::out_t mk_res(
		input logic [1:0]  kind,
		input logic [31:0] name,
		input logic [7:0]  idx,
		input logic        root,
		input logic [7:0]  parent,
		input logic [7:0]  count,
		input logic [1:0]  err
	);
		ansp_pkg::out_t r;
		r.result_kind   = kind;
		r.segment_name  = name;
		r.segment_index = idx;
		r.is_last       = 1'b1;
		r.root_present  = root;
		r.parent_depth  = parent;
		r.segment_count = count;
		r.error_code    = err;
		return r;
	endfunction

	function automatic ansp_pkg::step_t fail(input ansp_pkg::state_t s, input logic [1:0] code);
		ansp_pkg::step_t t;
		t.st   = ansp_pkg::STATE_CLEAR;
		t.emit = 1'b1;
		t.res  = mk_res(ansp_pkg::KIND_ERROR, 32'd0, s.segments_done, s.root_seen,
			s.parent_count, s.segments_total, code);
		return t;
	endfunction

	function automatic ansp_pkg::step_t empty_done(input ansp_pkg::state_t s);
		ansp_pkg::step_t t;
		t.st   = ansp_pkg::STATE_CLEAR;
		t.emit = 1'b1;
		t.res  = mk_res(ansp_pkg::KIND_EMPTY, 32'd0, 8'd0, s.root_seen, s.parent_count,
			8'd0, ansp_pkg::ERR_NONE);
		return t;
	endfunction

	function automatic ansp_pkg::step_t path_start(input ansp_pkg::state_t s, input logic [7:0] b);
		ansp_pkg::step_t t;
		t.st               = s;
		t.st.segments_done = 8'd0;
		t.st.char_position = 2'd0;
		t.st.segment_acc   = 24'd0;
		t.emit             = 1'b0;
		t.res              = '0;
		if (is_lead(b)) begin
			t.st.segments_total = 8'd1;
			t.st.segment_acc    = {16'd0, b};
			t.st.char_position  = 2'd1;
			t.st.phase          = ansp_pkg::PH_SEG;
		end else if (b == ansp_pkg::DUAL_PREFIX) begin
			t.st.segments_total = 8'd2;
			t.st.phase          = ansp_pkg::PH_SEG;
		end else if (b == ansp_pkg::MULTI_PREFIX) begin
			t.st.phase = ansp_pkg::PH_COUNT;
		end else if (b == ansp_pkg::NULL_NAME) begin
			t = empty_done(s);
		end else begin
			t = fail(s, ansp_pkg::ERR_PATH_START);
		end
		return t;
	endfunction

	function automatic ansp_pkg::step_t seg_byte(input ansp_pkg::state_t s, input logic [7:0] b);
		ansp_pkg::step_t t;
		logic            last;
		t.st   = s;
		t.emit = 1'b0;
		t.res  = '0;
		last   = ({1'b0, s.segments_done} + 9'd1) >= {1'b0, s.segments_total};
		if (s.char_position == 2'd0) begin
			if (!is_lead(b)) begin
				t = fail(s, ansp_pkg::ERR_LEAD_CHAR);
			end else begin
				t.st.segment_acc   = {16'd0, b};
				t.st.char_position = 2'd1;
			end
		end else if (!is_name(b)) begin
			t = fail(s, ansp_pkg::ERR_NAME_CHAR);
		end else if (s.char_position != ansp_pkg::TAIL_CHARS) begin
			if (s.char_position == 2'd1) begin
				t.st.segment_acc[15:8] = b;
			end else begin
				t.st.segment_acc[23:16] = b;
			end
			t.st.char_position = s.char_position + 2'd1;
		end else begin
			t.emit = 1'b1;
			t.res  = mk_res(ansp_pkg::KIND_SEG, {b, s.segment_acc}, s.segments_done,
				s.root_seen, s.parent_count, s.segments_total, ansp_pkg::ERR_NONE);
			t.res.is_last = last;
			if (last) begin
				t.st = ansp_pkg::STATE_CLEAR;
			end else begin
				t.st.segments_done = s.segments_done + 8'd1;
				t.st.char_position = 2'd0;
				t.st.segment_acc   = 24'd0;
			end
		end
		return t;
	endfunction

	ansp_pkg::state_t cur;
	ansp_pkg::state_t base;
	ansp_pkg::step_t  step;
	logic [7:0]       b;

	always_comb begin
		b    = data.data_byte;
		cur  = data.start_new ? ansp_pkg::STATE_CLEAR : state;
		base = ansp_pkg::STATE_CLEAR;
		step.st   = cur;
		step.emit = 1'b0;
		step.res  = '0;
		case (cur.phase)
			ansp_pkg::PH_PREFIX: begin
				if (b == ansp_pkg::PARENT_CHAR) begin
					if (cur.parent_count != ansp_pkg::PARENT_MAX) begin
						step.st.parent_count = cur.parent_count + 8'd1;
					end
				end else begin
					step = path_start(cur, b);
				end
			end
			ansp_pkg::PH_PATH: begin
				step = path_start(cur, b);
			end
			ansp_pkg::PH_COUNT: begin
				if (b == 8'd0) begin
					step = empty_done(cur);
				end else begin
					step.st.segments_total = b;
					step.st.segments_done  = 8'd0;
					step.st.char_position  = 2'd0;
					step.st.segment_acc    = 24'd0;
					step.st.phase          = ansp_pkg::PH_SEG;
				end
			end
			ansp_pkg::PH_SEG: begin
				step = seg_byte(cur, b);
			end
			default: begin
				// every byte seen while idle opens a new name string
				if (b == ansp_pkg::ROOT_CHAR) begin
					step.st           = base;
					step.st.root_seen = 1'b1;
					step.st.phase     = ansp_pkg::PH_PATH;
				end else if (b == ansp_pkg::PARENT_CHAR) begin
					step.st              = base;
					step.st.parent_count = 8'd1;
					step.st.phase        = ansp_pkg::PH_PREFIX;
				end else begin
					step = path_start(base, b);
				end
			end
		endcase
	end

	assign next_state = step.st;
	assign emit       = step.emit;
	assign res        = step.res;

endmodule

/* hw/rtl/acpi_name_string_parser_core.sv */
`timescale 1ns / 1ps

// Channel  Ports                                   Word
// -------  --------------------------------------  ------------------
// byte     byte_valid, byte_stall, byte_data       ansp_pkg::in_t
// res      res_valid,  res_stall,  res_data        ansp_pkg::out_t
//
// One byte per cycle, sustained while the result register can move. A byte
// is first held in the input register, then the parse step updates the state
// and loads the result register, from which the result is visible.
// arst_n clears the parse state and both valid flags.
// res_stall holds the result register; byte_stall rises only while the input
// register is full and the result register cannot move.

module acpi_name_string_parser_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_stall,
	input  ansp_pkg::in_t  byte_data,
	output logic           res_valid,
	input  logic           res_stall,
	output ansp_pkg::out_t res_data
);

	logic             in_valid_s1;
	ansp_pkg::in_t    in_s1;
	ansp_pkg::state_t state_q;
	ansp_pkg::state_t state_nxt;
	logic             res_valid_q;
	ansp_pkg::out_t   res_q;
	logic             step_emit;
	ansp_pkg::out_t   step_res;
	logic             out_free;
	logic             advance;

	assign out_free   = !res_valid_q || !res_stall;
	assign advance    = in_valid_s1 && out_free;
	assign byte_stall = in_valid_s1 && !out_free;

	ansp_step u_step (
		.state      (state_q),
		.data       (in_s1),
		.next_state (state_nxt),
		.emit       (step_emit),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			in_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			in_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ansp_pkg::STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && step_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_emit) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_emit |=> res_valid_q && (res_q == $past(step_res)))
		else $error("result word not loaded after parse step");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_emit && step_res.is_last |=> state_q.phase == ansp_pkg::PH_IDLE)
		else $error("parser not idle after final word");

	a_seg_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == ansp_pkg::PH_SEG |-> state_q.segments_done < state_q.segments_total)
		else $error("segment index ran past segment count");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(in_s1))
		else $error("pending input byte lost");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		ansp_pkg::in_t  word;
		logic           typed;
		ansp_pkg::out_t want;
	} dir_row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           byte_valid = 1'b0;
	logic           byte_stall;
	ansp_pkg::in_t  byte_data = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	ansp_pkg::out_t res_data;

	acpi_name_string_parser_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Parser prediction
	// ---------------------------------------------------------------
	ansp_pkg::phase_t ph;
	logic             root;
	logic [7:0]       parents;
	logic [7:0]       total;
	logic [7:0]       done;
	logic [1:0]       cpos;
	logic [23:0]      acc;

	ansp_pkg::out_t pending_results[$];
	int   mismatches = 0;
	int   words_sent = 0;
	int   burst_left = 0;
	bit   opening;
	bit   opening_sn;

	function automatic bit lead_ok(input logic [7:0] c);
		return (c >= ansp_pkg::CHAR_A && c <= ansp_pkg::CHAR_Z) || c == ansp_pkg::CHAR_US;
	endfunction

	function automatic bit name_ok(input logic [7:0] c);
		return lead_ok(c) || (c >= ansp_pkg::CHAR_0 && c <= ansp_pkg::CHAR_9);
	endfunction

	function automatic void wipe();
		ph = ansp_pkg::PH_IDLE;
		root = 1'b0;
		parents = 8'd0;
		total = 8'd0;
		done = 8'd0;
		cpos = 2'd0;
		acc = 24'd0;
	endfunction

	// root and depth come from the live state, so build before wiping
	function automatic ansp_pkg::out_t pack_res(input logic [1:0] kind,
			input logic [31:0] nm, input logic [7:0] idx, input logic last,
			input logic [7:0] cnt, input logic [1:0] err);
		ansp_pkg::out_t r;
		r.result_kind = kind;
		r.segment_name = nm;
		r.segment_index = idx;
		r.is_last = last;
		r.root_present = root;
		r.parent_depth = parents;
		r.segment_count = cnt;
		r.error_code = err;
		return r;
	endfunction

	function automatic ansp_pkg::out_t abort_parse(input logic [1:0] code);
		ansp_pkg::out_t r;
		r = pack_res(ansp_pkg::KIND_ERROR, 32'd0, done, 1'b1, total, code);
		wipe();
		return r;
	endfunction

	function automatic ansp_pkg::out_t empty_name();
		ansp_pkg::out_t r;
		r = pack_res(ansp_pkg::KIND_EMPTY, 32'd0, 8'd0, 1'b1, 8'd0, ansp_pkg::ERR_NONE);
		wipe();
		return r;
	endfunction

	function automatic bit open_path(input logic [7:0] b, output ansp_pkg::out_t r);
		r = '0;
		done = 8'd0;
		cpos = 2'd0;
		acc = 24'd0;
		if (lead_ok(b)) begin
			total = 8'd1;
			acc = {16'd0, b};
			cpos = 2'd1;
			ph = ansp_pkg::PH_SEG;
			return 1'b0;
		end
		if (b == ansp_pkg::DUAL_PREFIX) begin
			total = 8'd2;
			ph = ansp_pkg::PH_SEG;
			return 1'b0;
		end
		if (b == ansp_pkg::MULTI_PREFIX) begin
			ph = ansp_pkg::PH_COUNT;
			return 1'b0;
		end
		if (b == ansp_pkg::NULL_NAME) begin
			total = 8'd0;
			r = empty_name();
			return 1'b1;
		end
		r = abort_parse(ansp_pkg::ERR_PATH_START);
		return 1'b1;
	endfunction

	function automatic bit seg_char(input logic [7:0] b, output ansp_pkg::out_t r);
		logic [7:0] idx;
		logic       last;
		r = '0;
		if (cpos == 2'd0) begin
			if (!lead_ok(b)) begin
				r = abort_parse(ansp_pkg::ERR_LEAD_CHAR);
				return 1'b1;
			end
			acc = {16'd0, b};
			cpos = 2'd1;
			return 1'b0;
		end
		if (!name_ok(b)) begin
			r = abort_parse(ansp_pkg::ERR_NAME_CHAR);
			return 1'b1;
		end
		if (cpos < ansp_pkg::TAIL_CHARS) begin
			acc = acc | ({16'd0, b} << (8 * cpos));
			cpos = cpos + 2'd1;
			return 1'b0;
		end
		idx = done;
		last = ({1'b0, idx} + 9'd1) >= {1'b0, total};
		r = pack_res(ansp_pkg::KIND_SEG, {b, acc}, idx, last, total, ansp_pkg::ERR_NONE);
		if (last) begin
			wipe();
		end else begin
			done = done + 8'd1;
			cpos = 2'd0;
			acc = 24'd0;
		end
		return 1'b1;
	endfunction

	function automatic bit parse_step(input ansp_pkg::in_t w, output ansp_pkg::out_t r);
		logic [7:0] b;
		b = w.data_byte;
		r = '0;
		if (w.start_new)
			wipe();
		case (ph)
			ansp_pkg::PH_PREFIX: begin
				if (b == ansp_pkg::PARENT_CHAR) begin
					if (parents != ansp_pkg::PARENT_MAX)
						parents = parents + 8'd1;
					return 1'b0;
				end
				return open_path(b, r);
			end
			ansp_pkg::PH_PATH: begin
				return open_path(b, r);
			end
			ansp_pkg::PH_COUNT: begin
				if (b == 8'd0) begin
					r = empty_name();
					return 1'b1;
				end
				total = b;
				done = 8'd0;
				cpos = 2'd0;
				acc = 24'd0;
				ph = ansp_pkg::PH_SEG;
				return 1'b0;
			end
			ansp_pkg::PH_SEG: begin
				return seg_char(b, r);
			end
			default: begin
				wipe();
				if (b == ansp_pkg::ROOT_CHAR) begin
					root = 1'b1;
					ph = ansp_pkg::PH_PATH;
					return 1'b0;
				end
				if (b == ansp_pkg::PARENT_CHAR) begin
					parents = 8'd1;
					ph = ansp_pkg::PH_PREFIX;
					return 1'b0;
				end
				return open_path(b, r);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------
	task automatic report(input string msg);
		if (mismatches < 30)
			$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string fld, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", fld, got, want));
	endtask

	ansp_pkg::out_t head;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				head = pending_results.pop_front();
				check_field("result_kind", 32'(res_data.result_kind),
					32'(head.result_kind));
				check_field("segment_name", res_data.segment_name, head.segment_name);
				check_field("segment_index", 32'(res_data.segment_index),
					32'(head.segment_index));
				check_field("is_last", 32'(res_data.is_last), 32'(head.is_last));
				check_field("root_present", 32'(res_data.root_present),
					32'(head.root_present));
				check_field("parent_depth", 32'(res_data.parent_depth),
					32'(head.parent_depth));
				check_field("segment_count", 32'(res_data.segment_count),
					32'(head.segment_count));
				check_field("error_code", 32'(res_data.error_code),
					32'(head.error_code));
			end
		end
	end

	// receiver back-pressure: free, light, heavy and long blocks
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= ((stall_left / 8) % 2) == 1;
		endcase
	end

	// ---------------------------------------------------------------
	// Byte stream
	// ---------------------------------------------------------------
	task automatic send_word(input ansp_pkg::in_t w, input logic typed,
			input ansp_pkg::out_t want);
		int             gap;
		bit             has;
		ansp_pkg::out_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_data <= w;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		burst_left--;
		words_sent++;
		has = parse_step(w, r);
		if (typed)
			pending_results.push_back(want);
		else if (has)
			pending_results.push_back(r);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_byte(input logic [7:0] b);
		ansp_pkg::in_t w;
		w.data_byte = b;
		w.start_new = opening ? opening_sn : ($urandom_range(0, 149) == 0);
		opening = 1'b0;
		send_word(w, 1'b0, '0);
	endtask

	function automatic logic [7:0] lead_pick();
		int r;
		r = $urandom_range(0, 26);
		return (r == 26) ? ansp_pkg::CHAR_US : 8'(ansp_pkg::CHAR_A + r);
	endfunction

	function automatic logic [7:0] name_pick();
		int r;
		r = $urandom_range(0, 36);
		if (r < 26)
			return 8'(ansp_pkg::CHAR_A + r);
		if (r < 36)
			return 8'(ansp_pkg::CHAR_0 + (r - 26));
		return ansp_pkg::CHAR_US;
	endfunction

	// occasionally a char is replaced by an arbitrary byte
	task automatic put_seg();
		put_byte(($urandom_range(0, 59) == 0) ? 8'($urandom_range(0, 255)) : lead_pick());
		repeat (3)
			put_byte(($urandom_range(0, 59) == 0) ? 8'($urandom_range(0, 255)) : name_pick());
	endtask

	task automatic gen_name(input bit big);
		int pick;
		int n;
		int cnt;
		int segs;
		opening = 1'b1;
		opening_sn = 1'($urandom_range(0, 1));
		if (!big && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n)
				put_byte(8'($urandom_range(0, 255)));
			return;
		end
		pick = $urandom_range(0, 9);
		if (big) begin
			repeat (256)
				put_byte(ansp_pkg::PARENT_CHAR);
		end else if (pick >= 4 && pick <= 6) begin
			put_byte(ansp_pkg::ROOT_CHAR);
			if ($urandom_range(0, 14) == 0)
				put_byte($urandom_range(0, 1) ? ansp_pkg::PARENT_CHAR : ansp_pkg::ROOT_CHAR);
		end else if (pick >= 7) begin
			n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 4);
			repeat (n)
				put_byte(ansp_pkg::PARENT_CHAR);
		end
		pick = big ? 6 : $urandom_range(0, 9);
		if (!big && $urandom_range(0, 19) == 0) begin
			put_byte(8'($urandom_range(0, 255)));
		end else if (pick <= 3) begin
			put_seg();
		end else if (pick <= 5) begin
			put_byte(ansp_pkg::DUAL_PREFIX);
			put_seg();
			put_seg();
		end else if (pick <= 8) begin
			if (big)
				cnt = 255;
			else
				cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
			put_byte(ansp_pkg::MULTI_PREFIX);
			put_byte(8'(cnt));
			segs = cnt;
			// long multi names are mostly cut short
			if (!big && cnt > 12 && $urandom_range(0, 3) != 0)
				segs = $urandom_range(0, 12);
			repeat (segs)
				put_seg();
		end else begin
			put_byte(ansp_pkg::NULL_NAME);
		end
	endtask

	function automatic dir_row_t row(input logic [7:0] b, input logic sn,
			input logic typed, input ansp_pkg::out_t want);
		dir_row_t d;
		d.word.data_byte = b;
		d.word.start_new = sn;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		int       seqs;
		wipe();
		// expected words below are {kind, name, index, last, root, depth, count, error}
		dir_rows.push_back(row(ansp_pkg::NULL_NAME, 1'b1, 1'b1,
			{ansp_pkg::KIND_EMPTY, 32'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0,
			ansp_pkg::ERR_NONE}));
		dir_rows.push_back(row(ansp_pkg::CHAR_A, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::CHAR_Z, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::CHAR_US, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::CHAR_9, 1'b0, 1'b1,
			{ansp_pkg::KIND_SEG, 32'h395F5A41, 8'd0, 1'b1, 1'b0, 8'd0, 8'd1,
			ansp_pkg::ERR_NONE}));
		// root then parent is a bad path start
		dir_rows.push_back(row(ansp_pkg::ROOT_CHAR, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::PARENT_CHAR, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0,
			ansp_pkg::ERR_PATH_START}));
		dir_rows.push_back(row(ansp_pkg::PARENT_CHAR, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::PARENT_CHAR, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::DUAL_PREFIX, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::CHAR_0, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b0, 8'd2, 8'd2,
			ansp_pkg::ERR_LEAD_CHAR}));
		// multi prefix with zero count
		dir_rows.push_back(row(ansp_pkg::ROOT_CHAR, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::MULTI_PREFIX, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(8'h00, 1'b0, 1'b1,
			{ansp_pkg::KIND_EMPTY, 32'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0,
			ansp_pkg::ERR_NONE}));
		dir_rows.push_back(row(ansp_pkg::MULTI_PREFIX, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(8'h03, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(8'h51, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(8'h60, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd3,
			ansp_pkg::ERR_NAME_CHAR}));
		dir_rows.push_back(row(8'hFF, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0,
			ansp_pkg::ERR_PATH_START}));
		dir_rows.push_back(row(ansp_pkg::ROOT_CHAR, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::ROOT_CHAR, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0,
			ansp_pkg::ERR_PATH_START}));
		// start_new drops the open dual prefix
		dir_rows.push_back(row(ansp_pkg::DUAL_PREFIX, 1'b0, 1'b0, '0));
		dir_rows.push_back(row(ansp_pkg::CHAR_A, 1'b1, 1'b0, '0));
		dir_rows.push_back(row(8'h40, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd1,
			ansp_pkg::ERR_NAME_CHAR}));
		dir_rows.push_back(row(8'h5B, 1'b0, 1'b1,
			{ansp_pkg::KIND_ERROR, 32'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0,
			ansp_pkg::ERR_PATH_START}));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		drain();

		// saturated parent run plus a full 255-segment path
		gen_name(1'b1);
		drain();

		seqs = 0;
		while (words_sent < 1800) begin
			gen_name(1'b0);
			seqs++;
			if (seqs % 40 == 0)
				drain();
		end
		byte_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
